>>> rtl/sorted_value_table_defines.svh
// Assertion macros shared by the sorted value table checker.
`ifndef SORTED_VALUE_TABLE_DEFINES_SVH
`define SORTED_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define SVT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock and off during reset.
`define SVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/svt_pkg.sv
// Shared types and constants of the sorted value table.
package svt_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 7;

    // Request codes; the last code performs no operation.
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NOP    = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_EMIT
    } state_t;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic load_cmp;
        logic shift_up;
        logic shift_down;
    } cell_ctl_t;

    // Flags that each cell reports to the sequencer and its right neighbor.
    typedef struct packed {
        logic gt;
        logic ge;
        logic hit_ins;
        logic hit_del;
        logic is_last;
    } cell_flags_t;

endpackage

>>> rtl/sorted_value_table.sv
// Sorted value table: a chain of cells that keeps signed values in ascending order.
//
// Input channel (in_valid/in_ready) carries req_type and value: insert in order,
// delete the first equal entry, or search for the first equal entry. The output
// channel (out_valid/out_ready) returns one item per request with status,
// 1-based position, entry_count, smallest and largest after the operation.
// The table takes no new item until the previous one has finished: all cells
// compare against the value at the acceptance edge, the sequencer then locates
// the boundary cell in its scan state, the chain shifts in the update state,
// and the result is registered in the emit state.
// A new item is taken in the same cycle that the previous result is loaded.
// When the receiver stalls, the result stays in the output register and the
// sequencer holds the next finished item until the register frees up.
// Reset empties the table (count zero) and clears all control state; stored
// entries need no clearing since only occupied cells are ever reported.
module sorted_value_table #(
    parameter int DEPTH = svt_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [svt_pkg::REQ_W-1:0]            req_type,
    input  logic signed [svt_pkg::DATA_W-1:0]    value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [svt_pkg::STATUS_W-1:0]         status,
    output logic [svt_pkg::POS_W-1:0]            position,
    output logic [svt_pkg::POS_W-1:0]            entry_count,
    output logic signed [svt_pkg::DATA_W-1:0]    smallest,
    output logic signed [svt_pkg::DATA_W-1:0]    largest
);
    import svt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                   state_reg, state_next;
    req_t                     req_reg, req_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    status_t                  st_reg, st_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic                     up_reg, up_next;
    logic                     down_reg, down_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_st_reg, out_st_next;
    logic [CNT_W-1:0]         out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]         out_cnt_reg, out_cnt_next;
    logic signed [DATA_W-1:0] out_min_reg, out_min_next;
    logic signed [DATA_W-1:0] out_max_reg, out_max_next;

    cell_ctl_t                ctl;
    logic                     accept;
    logic                     out_free;
    logic                     scan_en;
    logic                     emit_en;
    logic                     found;
    logic                     full;
    logic [CNT_W-1:0]         pos_ins;
    logic [CNT_W-1:0]         pos_del;
    logic signed [DATA_W-1:0] last_value;

    logic signed [DATA_W-1:0] cell_value [DEPTH];
    cell_flags_t              cell_flags [DEPTH];

    // Chain of cells; each sees its left and right neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] right_value;
        logic                     left_gt;
        logic                     left_ge;

        if (i == 0)
        begin : g_first
            assign left_value = v_reg;
            assign left_gt    = 1'b0;
            assign left_ge    = 1'b0;
        end
        else
        begin : g_inner
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_flags[i-1].gt;
            assign left_ge    = cell_flags[i-1].ge;
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
        end

        svt_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .cmp_value   (value),
            .ins_value   (v_reg),
            .left_value  (left_value),
            .right_value (right_value),
            .left_gt     (left_gt),
            .left_ge     (left_ge),
            .count       (count_reg),
            .entry_value (cell_value[i]),
            .flags       (cell_flags[i])
        );
    end

    assign out_free = !out_valid_reg || out_ready;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = in_valid ? S_SCAN : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready       = 1'b0;
        scan_en        = 1'b0;
        emit_en        = 1'b0;
        ctl.shift_up   = 1'b0;
        ctl.shift_down = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SCAN:
            begin
                scan_en = 1'b1;
            end
            S_UPD:
            begin
                ctl.shift_up   = up_reg;
                ctl.shift_down = down_reg;
            end
            S_EMIT:
            begin
                in_ready = out_free;
                emit_en  = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        accept       = in_valid && in_ready;
        ctl.load_cmp = accept;
    end

    // Encode the boundary cells and the last occupied cell from the one-hot flags.
    always_comb
    begin
        found      = 1'b0;
        pos_ins    = '0;
        pos_del    = '0;
        last_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found = found | cell_flags[i].hit_del;
            if (cell_flags[i].hit_ins)
            begin
                pos_ins = pos_ins | CNT_W'(i + 1);
            end
            if (cell_flags[i].hit_del)
            begin
                pos_del = pos_del | CNT_W'(i + 1);
            end
            if (cell_flags[i].is_last)
            begin
                last_value = last_value | cell_value[i];
            end
        end
        full = count_reg == CNT_W'(DEPTH);
    end

    // Request decode, boundary result, count update and output register load.
    always_comb
    begin
        req_next       = req_reg;
        v_next         = v_reg;
        count_next     = count_reg;
        st_next        = st_reg;
        pos_next       = pos_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_pos_next   = out_pos_reg;
        out_cnt_next   = out_cnt_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;

        if (accept)
        begin
            req_next = req_t'(req_type);
            v_next   = value;
        end

        if (scan_en)
        begin
            st_next   = ST_OK;
            pos_next  = '0;
            up_next   = 1'b0;
            down_next = 1'b0;
            case (req_reg)
                REQ_INSERT:
                begin
                    if (full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        pos_next = pos_ins;
                        up_next  = 1'b1;
                    end
                end
                REQ_DELETE:
                begin
                    if (found)
                    begin
                        pos_next  = pos_del;
                        down_next = 1'b1;
                    end
                    else
                    begin
                        st_next = ST_MISSING;
                    end
                end
                REQ_SEARCH:
                begin
                    if (found)
                    begin
                        pos_next = pos_del;
                    end
                    else
                    begin
                        st_next = ST_MISSING;
                    end
                end
                default:
                begin
                    st_next = ST_OK;
                end
            endcase
        end

        if (ctl.shift_up)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.shift_down)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_en)
        begin
            out_valid_next = 1'b1;
            out_st_next    = st_reg;
            out_pos_next   = pos_reg;
            out_cnt_next   = count_reg;
            out_min_next   = (count_reg != '0) ? cell_value[0] : '0;
            out_max_next   = last_value;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            up_reg        <= 1'b0;
            down_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            up_reg        <= up_next;
            down_reg      <= down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        v_reg       <= v_next;
        st_reg      <= st_next;
        pos_reg     <= pos_next;
        out_st_reg  <= out_st_next;
        out_pos_reg <= out_pos_next;
        out_cnt_reg <= out_cnt_next;
        out_min_reg <= out_min_next;
        out_max_reg <= out_max_next;
    end

    // Output ports; position and count are reported in seven bits.
    assign out_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign position    = POS_W'(out_pos_reg);
    assign entry_count = POS_W'(out_cnt_reg);
    assign smallest    = out_min_reg;
    assign largest     = out_max_reg;

endmodule

>>> rtl/svt_cell.sv
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
module svt_cell #(
    parameter int DEPTH = svt_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  svt_pkg::cell_ctl_t                 ctl,
    input  logic signed [svt_pkg::DATA_W-1:0]  cmp_value,
    input  logic signed [svt_pkg::DATA_W-1:0]  ins_value,
    input  logic signed [svt_pkg::DATA_W-1:0]  left_value,
    input  logic signed [svt_pkg::DATA_W-1:0]  right_value,
    input  logic                               left_gt,
    input  logic                               left_ge,
    input  logic [$clog2(DEPTH+1)-1:0]         count,
    output logic signed [svt_pkg::DATA_W-1:0]  entry_value,
    output svt_pkg::cell_flags_t               flags
);
    import svt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     gt_reg;
    logic                     eq_reg;
    logic                     occ;

    // Occupancy and boundary flags; an empty cell counts as larger than any value.
    always_comb
    begin
        occ           = CNT_W'(IDX) < count;
        flags.gt      = !occ || gt_reg;
        flags.ge      = occ && (gt_reg || eq_reg);
        flags.hit_ins = flags.gt && !left_gt;
        flags.hit_del = occ && eq_reg && !left_ge;
        flags.is_last = count == CNT_W'(IDX + 1);
    end

    // Insert moves larger entries up one cell; delete pulls later entries down.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_up && flags.gt)
        begin
            entry_next = left_gt ? left_value : ins_value;
        end
        else if (ctl.shift_down && flags.ge)
        begin
            entry_next = right_value;
        end
    end

    // Entry storage; contents are meaningless until written.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Compare flags, captured when an item is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctl.load_cmp)
        begin
            gt_reg <= entry_reg > cmp_value;
            eq_reg <= entry_reg == cmp_value;
        end
    end

    assign entry_value = entry_reg;

endmodule

>>> rtl/svt_checker.sv
// Port-level checker for the sorted value table and its bind statement.
`include "sorted_value_table_defines.svh"

module svt_checker #(
    parameter int DEPTH = svt_pkg::DEPTH_DEFAULT
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [svt_pkg::REQ_W-1:0]         req_type,
    input logic signed [svt_pkg::DATA_W-1:0] value,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [svt_pkg::STATUS_W-1:0]      status,
    input logic [svt_pkg::POS_W-1:0]         position,
    input logic [svt_pkg::POS_W-1:0]         entry_count,
    input logic signed [svt_pkg::DATA_W-1:0] smallest,
    input logic signed [svt_pkg::DATA_W-1:0] largest
);
    import svt_pkg::*;

    // A stalled result item holds its contents.
    `SVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(position) && $stable(entry_count) && $stable(smallest) && $stable(largest), "output item changed while stalled")

    // A waiting input item holds its contents.
    `SVT_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(req_type) && $stable(value), "input item changed while waiting")

    // The table works on one item at a time.
    `SVT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item accepted while busy")

    // A refused insert only happens on a full table and names no position.
    `SVT_ASSERT_SAME(a_full, out_valid && status == ST_FULL, position == '0 && entry_count == POS_W'(DEPTH), "full status with position or wrong count")

    // A missed value names no position.
    `SVT_ASSERT_SAME(a_missing, out_valid && status == ST_MISSING, position == '0, "missing status with a position")

endmodule

bind sorted_value_table svt_checker #(.DEPTH(DEPTH)) u_svt_checker (.*);
